// ===== rtl/idpsc_pkg.sv =====
// Shared types and constants for the I/Q packet deframer with sequence check.
package idpsc_pkg;

    localparam int unsigned HDR_LEN    = 6;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] MAGIC_0 = 8'h44;  // 'D'
    localparam logic [7:0] MAGIC_1 = 8'h54;  // 'T'

    localparam logic [1:0] PAIR_LAST_PHASE = 2'd3;

    localparam logic [2:0] ST_IN_ORDER = 3'd0;
    localparam logic [2:0] ST_GAP      = 3'd1;
    localparam logic [2:0] ST_STALE    = 3'd2;
    localparam logic [2:0] ST_NOT_DATA = 3'd3;
    localparam logic [2:0] ST_RX_MODE  = 3'd4;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               item_kind;
        logic signed [15:0] in_phase;
        logic signed [15:0] quadrature;
        logic [15:0]        pair_index;
        logic [2:0]         packet_status;
        logic               run_end;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== rtl/idpsc_core.sv =====
// Header parse, sequence check and sample assembly, one byte per request.
module idpsc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first_byte,
    input  logic                 i_last_byte,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    output idpsc_pkg::t_push     o_push
);

    logic        r_transmit_enable;
    logic [2:0]  r_header_position, n_header_position;
    logic [31:0] r_header_hold,     n_header_hold;
    logic [15:0] r_expected_seq,    n_expected_seq;
    logic        r_expected_valid,  n_expected_valid;
    logic [15:0] r_declared_pairs,  n_declared_pairs;
    logic [15:0] r_pairs_done,      n_pairs_done;
    logic [23:0] r_pair_bytes,      n_pair_bytes;
    logic [1:0]  r_pair_phase,      n_pair_phase;
    logic [2:0]  r_verdict,         n_verdict;

    always_comb begin
        logic [2:0]  c_hp;
        logic [31:0] c_hold;
        logic [15:0] c_dp;
        logic [15:0] c_pd;
        logic [23:0] c_pb;
        logic [1:0]  c_ph;
        logic [2:0]  c_pv;
        logic [1:0]  hold_sel;
        logic [15:0] seq;
        logic [16:0] seq_plus;
        logic        sample_out;
        idpsc_pkg::t_result sample_res;
        idpsc_pkg::t_result status_res;

        c_hp   = i_first_byte ? 3'd0  : r_header_position;
        c_hold = i_first_byte ? 32'd0 : r_header_hold;
        c_dp   = i_first_byte ? 16'd0 : r_declared_pairs;
        c_pd   = i_first_byte ? 16'd0 : r_pairs_done;
        c_pb   = i_first_byte ? 24'd0 : r_pair_bytes;
        c_ph   = i_first_byte ? 2'd0  : r_pair_phase;
        c_pv   = i_first_byte ? idpsc_pkg::ST_IN_ORDER : r_verdict;

        n_header_position = c_hp;
        n_header_hold     = c_hold;
        n_declared_pairs  = c_dp;
        n_pairs_done      = c_pd;
        n_pair_bytes      = c_pb;
        n_pair_phase      = c_ph;
        n_verdict         = c_pv;
        n_expected_seq    = r_expected_seq;
        n_expected_valid  = r_expected_valid;
        sample_out        = 1'b0;
        hold_sel          = c_hp[1:0] - 2'd2;
        seq               = 16'd0;
        seq_plus          = 17'd0;

        sample_res               = '0;
        sample_res.item_kind     = idpsc_pkg::KIND_SAMPLE;
        sample_res.in_phase      = c_pb[23:8];
        sample_res.quadrature    = {c_pb[7:0], i_data_byte};
        sample_res.pair_index    = c_pd;
        sample_res.packet_status = idpsc_pkg::ST_IN_ORDER;

        if (c_hp < 3'(idpsc_pkg::HDR_LEN)) begin
            if (c_hp == 3'd0) begin
                if (i_data_byte != idpsc_pkg::MAGIC_0) begin
                    n_verdict = idpsc_pkg::ST_NOT_DATA;
                end
            end else if (c_hp == 3'd1) begin
                if (i_data_byte != idpsc_pkg::MAGIC_1) begin
                    n_verdict = idpsc_pkg::ST_NOT_DATA;
                end
            end else begin
                n_header_hold[{hold_sel, 3'b000} +: 8] = i_data_byte;
            end
            n_header_position = c_hp + 3'd1;
            if (n_header_position == 3'(idpsc_pkg::HDR_LEN) &&
                n_verdict != idpsc_pkg::ST_NOT_DATA) begin
                seq              = n_header_hold[15:0];
                seq_plus         = {1'b0, seq} + 17'd2;
                n_declared_pairs = n_header_hold[31:16];
                if (r_expected_valid && seq != r_expected_seq &&
                    seq < r_expected_seq && seq[0] == r_expected_seq[0]) begin
                    n_verdict = idpsc_pkg::ST_STALE;
                end else begin
                    if (r_expected_valid && seq != r_expected_seq) begin
                        n_verdict = idpsc_pkg::ST_GAP;
                    end
                    // past the top the count wraps with a parity flip
                    n_expected_seq   = seq_plus[16] ? {15'd0, ~seq[0]} : seq_plus[15:0];
                    n_expected_valid = 1'b1;
                    if (!r_transmit_enable) begin
                        n_verdict = idpsc_pkg::ST_RX_MODE;
                    end
                end
            end
        end else if ((c_pv == idpsc_pkg::ST_IN_ORDER || c_pv == idpsc_pkg::ST_GAP) &&
                     c_pd < c_dp) begin
            if (c_ph == idpsc_pkg::PAIR_LAST_PHASE) begin
                sample_out   = 1'b1;
                n_pairs_done = c_pd + 16'd1;
                n_pair_phase = 2'd0;
                n_pair_bytes = 24'd0;
            end else begin
                n_pair_bytes = {c_pb[15:0], i_data_byte};
                n_pair_phase = c_ph + 2'd1;
            end
        end

        status_res               = '0;
        status_res.item_kind     = idpsc_pkg::KIND_STATUS;
        status_res.pair_index    = n_pairs_done;
        status_res.packet_status = (n_header_position < 3'(idpsc_pkg::HDR_LEN)) ?
                                   idpsc_pkg::ST_NOT_DATA : n_verdict;
        status_res.run_end       = 1'b1;

        o_push = '0;
        if (sample_out && i_last_byte) begin
            o_push.count  = 2'd2;
            o_push.first  = sample_res;
            o_push.second = status_res;
        end else if (sample_out) begin
            o_push.count         = 2'd1;
            o_push.first         = sample_res;
            o_push.first.run_end = 1'b1;
        end else if (i_last_byte) begin
            o_push.count = 2'd1;
            o_push.first = status_res;
        end
        if (!i_accept) begin
            o_push.count = 2'd0;
        end

        if (i_last_byte) begin
            n_header_position = 3'd0;
            n_header_hold     = 32'd0;
            n_declared_pairs  = 16'd0;
            n_pairs_done      = 16'd0;
            n_pair_bytes      = 24'd0;
            n_pair_phase      = 2'd0;
            n_verdict         = idpsc_pkg::ST_IN_ORDER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transmit_enable <= 1'b0;
            r_header_position <= 3'd0;
            r_header_hold     <= 32'd0;
            r_expected_seq    <= 16'd0;
            r_expected_valid  <= 1'b0;
            r_declared_pairs  <= 16'd0;
            r_pairs_done      <= 16'd0;
            r_pair_bytes      <= 24'd0;
            r_pair_phase      <= 2'd0;
            r_verdict         <= idpsc_pkg::ST_IN_ORDER;
        end else begin
            if (i_cfg_wr_en) begin
                r_transmit_enable <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_header_position <= n_header_position;
                r_header_hold     <= n_header_hold;
                r_expected_seq    <= n_expected_seq;
                r_expected_valid  <= n_expected_valid;
                r_declared_pairs  <= n_declared_pairs;
                r_pairs_done      <= n_pairs_done;
                r_pair_bytes      <= n_pair_bytes;
                r_pair_phase      <= n_pair_phase;
                r_verdict         <= n_verdict;
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |=> r_header_position == 3'd0 && r_pairs_done == 16'd0)
        else $error("packet state not cleared after last byte");

    a_pairs_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_position == 3'(idpsc_pkg::HDR_LEN) |-> r_pairs_done <= r_declared_pairs)
        else $error("more pairs emitted than declared");

    a_no_samples_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count != 2'd0 && o_push.first.item_kind == idpsc_pkg::KIND_SAMPLE |->
        r_verdict == idpsc_pkg::ST_IN_ORDER || r_verdict == idpsc_pkg::ST_GAP ||
        i_first_byte)
        else $error("sample emitted for a packet that is not forwarded");

endmodule

// ===== rtl/idpsc_out_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle when popped.
module idpsc_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idpsc_pkg::t_push     i_push,
    input  logic                 i_pop,
    output logic                 o_full2,
    output logic                 o_valid,
    output idpsc_pkg::t_result   o_head
);

    localparam int unsigned AW = idpsc_pkg::FIFO_AW;
    localparam int unsigned CW = idpsc_pkg::FIFO_CW;

    idpsc_pkg::t_result r_mem [idpsc_pkg::FIFO_DEPTH];
    logic [AW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      wr_ptr_2;

    assign wr_ptr_2 = r_wr_ptr + AW'(1);
    assign o_valid  = r_count != '0;
    assign o_head   = r_mem[r_rd_ptr];
    assign o_full2  = r_count > CW'(idpsc_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_2] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + AW'(i_pop);
            r_count  <= r_count + CW'(i_push.count) - CW'(i_pop);
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd0 |-> r_count <= CW'(idpsc_pkg::FIFO_DEPTH - 2))
        else $error("result queue overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty result queue");

endmodule

// ===== rtl/iq_packet_deframer_seq_check.sv =====
// Top level of the I/Q packet deframer with sequence check.
//
//  channel  direction  handshake               payload
//  in       sink       i_in_valid/o_in_stall   i_data_byte, i_first_byte, i_last_byte
//  out      source     o_out_valid/i_out_stall o_item_kind, o_in_phase, o_quadrature,
//                                              o_pair_index, o_packet_status, o_run_end
//  cfg      sink       i_cfg_wr_en             i_cfg_wr_data (transmit enable)
//
// One byte accepted per cycle unless stalled; its results are in the queue the next cycle.
// A last byte that completes a pair gives two results, drained one per unstalled cycle
// through a four-entry queue; o_in_stall is high while fewer than two slots are free.
// Reset is synchronous, active low, and clears all packet and sequence state.
// An output stall holds the head result; input flows until fewer than two slots are free.
module iq_packet_deframer_seq_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_last_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_item_kind,
    output logic signed [15:0] o_in_phase,
    output logic signed [15:0] o_quadrature,
    output logic [15:0]        o_pair_index,
    output logic [2:0]         o_packet_status,
    output logic               o_run_end,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);

    logic               accept;
    logic               pop;
    idpsc_pkg::t_push   push;
    idpsc_pkg::t_result head;

    assign accept = i_in_valid && !o_in_stall;
    assign pop    = o_out_valid && !i_out_stall;

    idpsc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push)
    );

    idpsc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full2 (o_in_stall),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_item_kind     = head.item_kind;
    assign o_in_phase      = head.in_phase;
    assign o_quadrature    = head.quadrature;
    assign o_pair_index    = head.pair_index;
    assign o_packet_status = head.packet_status;
    assign o_run_end       = head.run_end;

endmodule

// ===== bench/iq_packet_deframer_seq_check_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the I/Q packet deframer: byte traffic, predictor, result compare.
module iq_packet_deframer_seq_check_tb;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 880;
    localparam int IDLE_PCT     = 27;
    localparam int HOLDOFF_LEN  = 100;
    localparam int REPORT_MAX   = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_data_byte;
    logic               i_first_byte;
    logic               i_last_byte;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_item_kind;
    logic signed [15:0] o_in_phase;
    logic signed [15:0] o_quadrature;
    logic [15:0]        o_pair_index;
    logic [2:0]         o_packet_status;
    logic               o_run_end;
    logic               i_cfg_wr_en;
    logic               i_cfg_wr_data;

    iq_packet_deframer_seq_check u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_item_kind     (o_item_kind),
        .o_in_phase      (o_in_phase),
        .o_quadrature    (o_quadrature),
        .o_pair_index    (o_pair_index),
        .o_packet_status (o_packet_status),
        .o_run_end       (o_run_end),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // predictor state
    logic [2:0]  m_hdr_pos;
    logic [31:0] m_hdr_hold;
    logic [15:0] m_exp_seq;
    logic        m_exp_valid;
    logic [15:0] m_decl_pairs;
    logic [15:0] m_pairs_done;
    logic [23:0] m_pair_bytes;
    logic [1:0]  m_pair_phase;
    logic [2:0]  m_verdict;
    logic        m_tx_en;

    idpsc_pkg::t_result pending_out[$];
    logic [7:0]  frame[$];
    int          fail_count = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    int          holdoff_req = 0;
    int          holdoff_left = 0;

    function automatic void clear_packet();
        m_hdr_pos    = '0;
        m_hdr_hold   = '0;
        m_decl_pairs = '0;
        m_pairs_done = '0;
        m_pair_bytes = '0;
        m_pair_phase = '0;
        m_verdict    = idpsc_pkg::ST_IN_ORDER;
    endfunction

    function automatic void check_seq_number();
        logic [15:0] seq;
        logic [16:0] nxt;
        seq          = m_hdr_hold[15:0];
        m_decl_pairs = m_hdr_hold[31:16];
        if (m_exp_valid && seq != m_exp_seq) begin
            if (seq < m_exp_seq && seq[0] == m_exp_seq[0]) begin
                m_verdict = idpsc_pkg::ST_STALE;
                return;
            end
            m_verdict = idpsc_pkg::ST_GAP;
        end
        nxt = {1'b0, seq} + 17'd2;
        if (nxt > 17'h0FFFF) begin
            m_exp_seq = nxt[0] ? 16'd0 : 16'd1;
        end else begin
            m_exp_seq = nxt[15:0];
        end
        m_exp_valid = 1'b1;
        if (!m_tx_en) begin
            m_verdict = idpsc_pkg::ST_RX_MODE;
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic f, input logic l);
        idpsc_pkg::t_result res[2];
        int      n;
        n = 0;
        if (f) begin
            clear_packet();
        end
        if (m_hdr_pos < idpsc_pkg::HDR_LEN) begin
            if (m_hdr_pos == 3'd0) begin
                if (b != idpsc_pkg::MAGIC_0) m_verdict = idpsc_pkg::ST_NOT_DATA;
            end else if (m_hdr_pos == 3'd1) begin
                if (b != idpsc_pkg::MAGIC_1) m_verdict = idpsc_pkg::ST_NOT_DATA;
            end else begin
                m_hdr_hold[(int'(m_hdr_pos) - 2) * 8 +: 8] = b;
            end
            m_hdr_pos++;
            if (m_hdr_pos == idpsc_pkg::HDR_LEN && m_verdict != idpsc_pkg::ST_NOT_DATA) begin
                check_seq_number();
            end
        end else if (m_verdict <= idpsc_pkg::ST_GAP && m_pairs_done < m_decl_pairs) begin
            if (m_pair_phase == idpsc_pkg::PAIR_LAST_PHASE) begin
                res[n]            = '0;
                res[n].item_kind  = idpsc_pkg::KIND_SAMPLE;
                res[n].in_phase   = m_pair_bytes[23:8];
                res[n].quadrature = {m_pair_bytes[7:0], b};
                res[n].pair_index = m_pairs_done;
                n++;
                m_pairs_done++;
                m_pair_phase = '0;
                m_pair_bytes = '0;
            end else begin
                m_pair_bytes = {m_pair_bytes[15:0], b};
                m_pair_phase++;
            end
        end
        if (l) begin
            res[n]               = '0;
            res[n].item_kind     = idpsc_pkg::KIND_STATUS;
            res[n].pair_index    = m_pairs_done;
            res[n].packet_status = (m_hdr_pos < idpsc_pkg::HDR_LEN) ?
                                   idpsc_pkg::ST_NOT_DATA : m_verdict;
            n++;
            clear_packet();
        end
        if (n > 0) begin
            res[n-1].run_end = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_out.push_back(res[i]);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("iq_packet_deframer_seq_check_tb: FAIL");
        $finish;
    end

    // output side: random stall, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (holdoff_req != 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (holdoff_left != 0) begin
            i_out_stall = 1'b1;
            holdoff_left--;
        end else begin
            i_out_stall = rx_gaps_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        idpsc_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_out.size() == 0) begin
                if (fail_count < REPORT_MAX) begin
                    $display("%0t: unexpected result kind=%0d i=%0d q=%0d idx=%0d st=%0d end=%0d",
                             $realtime, o_item_kind, o_in_phase, o_quadrature, o_pair_index,
                             o_packet_status, o_run_end);
                end
                fail_count++;
            end else begin
                want = pending_out.pop_front();
                if (o_item_kind !== want.item_kind || o_in_phase !== want.in_phase ||
                    o_quadrature !== want.quadrature || o_pair_index !== want.pair_index ||
                    o_packet_status !== want.packet_status || o_run_end !== want.run_end) begin
                    if (fail_count < REPORT_MAX) begin
                        $display("%0t: mismatch exp kind=%0d i=%0d q=%0d idx=%0d st=%0d end=%0d",
                                 $realtime, want.item_kind, want.in_phase, want.quadrature,
                                 want.pair_index, want.packet_status, want.run_end);
                        $display("%0t:          got kind=%0d i=%0d q=%0d idx=%0d st=%0d end=%0d",
                                 $realtime, o_item_kind, o_in_phase, o_quadrature,
                                 o_pair_index, o_packet_status, o_run_end);
                    end
                    fail_count++;
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        while (tx_gaps_on && $urandom_range(99) < IDLE_PCT) @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_data_byte  = b;
        i_first_byte = f;
        i_last_byte  = l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        deframe_byte(b, f, l);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_frame(input logic f, input logic l);
        foreach (frame[i]) begin
            send_byte(frame[i], f && i == 0, l && i == frame.size() - 1);
        end
    endtask

    task automatic put_header(input logic [15:0] seq, input logic [15:0] count);
        frame = '{idpsc_pkg::MAGIC_0, idpsc_pkg::MAGIC_1, seq[7:0], seq[15:8],
                  count[7:0], count[15:8]};
    endtask

    task automatic wait_drained();
        while (pending_out.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tx_enable(input logic v);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(posedge i_clk);
        m_tx_en = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic test_framing_errors();
        write_tx_enable(1'b1);
        send_byte(idpsc_pkg::MAGIC_0, 1'b1, 1'b1);
        frame = '{idpsc_pkg::MAGIC_0, idpsc_pkg::MAGIC_1, 8'h00};
        send_frame(1'b1, 1'b1);
        // bad magic, no first mark
        frame = '{idpsc_pkg::MAGIC_0, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00,
                  8'h12, 8'h34, 8'h56, 8'h78};
        send_frame(1'b0, 1'b1);
    endtask

    task automatic test_sequence_check();
        put_header(16'hFFFE, 16'd0);
        send_frame(1'b1, 1'b1);
        put_header(16'hFFFF, 16'd0);
        send_frame(1'b1, 1'b1);
        put_header(16'h0004, 16'd0);
        send_frame(1'b1, 1'b1);
        put_header(16'h0002, 16'd0);
        send_frame(1'b1, 1'b1);
    endtask

    task automatic test_sample_decode();
        put_header(m_exp_seq, 16'd2);
        frame.push_back(8'h7F); frame.push_back(8'hFF); frame.push_back(8'h80);
        frame.push_back(8'h00); frame.push_back(8'h00); frame.push_back(8'h00);
        frame.push_back(8'hFF); frame.push_back(8'hFF);
        send_frame(1'b1, 1'b1);
        // abandoned packet, then one pair plus bytes past the count
        frame = '{idpsc_pkg::MAGIC_0, idpsc_pkg::MAGIC_1, 8'h55};
        send_frame(1'b1, 1'b0);
        put_header(m_exp_seq, 16'd1);
        frame.push_back(8'h01); frame.push_back(8'h02); frame.push_back(8'h03);
        frame.push_back(8'h04); frame.push_back(8'hA5); frame.push_back(8'h5A);
        send_frame(1'b1, 1'b1);
        // ends inside the second pair
        put_header(m_exp_seq, 16'd2);
        frame.push_back(8'h10); frame.push_back(8'h20); frame.push_back(8'h30);
        frame.push_back(8'h40); frame.push_back(8'h50); frame.push_back(8'h60);
        send_frame(1'b1, 1'b1);
    endtask

    task automatic test_receive_mode();
        write_tx_enable(1'b0);
        put_header(m_exp_seq + 16'd4, 16'd1);
        frame.push_back(8'hC3); frame.push_back(8'h3C); frame.push_back(8'h81);
        frame.push_back(8'h18);
        send_frame(1'b1, 1'b1);
    endtask

    task automatic test_output_holdoff();
        write_tx_enable(1'b1);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        @(posedge i_clk);
        holdoff_req = HOLDOFF_LEN;
        @(negedge i_clk);
        put_header(m_exp_seq, 16'd12);
        repeat (48) frame.push_back(8'($urandom_range(255)));
        send_frame(1'b1, 1'b1);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic build_random_frame(output logic f, output logic l);
        int          pick;
        int          len;
        logic [15:0] seq;
        logic [15:0] count;
        pick = $urandom_range(99);
        if (pick < 12) begin
            frame = {};
            repeat ($urandom_range(8, 1)) frame.push_back(8'($urandom_range(255)));
            f = 1'($urandom_range(1));
            l = ($urandom_range(3) != 0);
            return;
        end
        pick = $urandom_range(99);
        if (pick < 55) seq = m_exp_seq;
        else if (pick < 70) seq = m_exp_seq - 16'(2 * $urandom_range(8, 1));
        else if (pick < 80) seq = m_exp_seq + 16'($urandom_range(9, 1));
        else if (pick < 88) seq = 16'hFFFE + 16'($urandom_range(1));
        else seq = 16'($urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 3) count = 16'($urandom_range(16'hFFFF));
        else if (pick < 13) count = 16'($urandom_range(12, 5));
        else count = 16'($urandom_range(4));
        put_header(seq, count);
        if ($urandom_range(99) < 5) begin
            frame[$urandom_range(1)] = 8'($urandom_range(255));
        end
        len = (count > 16'd12 ? 8 : 4 * int'(count)) + $urandom_range(6) - 3;
        if (len < 0) len = 0;
        repeat (len) frame.push_back(8'($urandom_range(255)));
        f = ($urandom_range(99) < 85);
        l = ($urandom_range(99) < 92);
    endtask

    task automatic test_random_traffic();
        int   sent;
        logic f;
        logic l;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) write_tx_enable(1'b0);
            else if (phase == 3) write_tx_enable(1'($urandom_range(1)));
            else write_tx_enable(1'b1);
            tx_gaps_on = (phase != 2);
            rx_gaps_on = (phase != 2);
            sent = 0;
            while (sent < RANDOM_BYTES / 4) begin
                build_random_frame(f, l);
                send_frame(f, l);
                sent += frame.size();
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_first_byte  = 1'b0;
        i_last_byte   = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        m_tx_en       = 1'b0;
        m_exp_seq     = '0;
        m_exp_valid   = 1'b0;
        clear_packet();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_framing_errors();
        test_sequence_check();
        test_sample_decode();
        test_receive_mode();
        test_output_holdoff();
        test_random_traffic();

        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("iq_packet_deframer_seq_check_tb: PASS");
        end else begin
            $display("iq_packet_deframer_seq_check_tb: FAIL");
        end
        $finish;
    end

endmodule
